// ===== hw/rtl/gdad_pkg.sv =====
`timescale 1ns / 1ps

package gdad_pkg;

  localparam int unsigned AddWidthDef = 16;
  localparam int unsigned MaxYearDef  = 9999;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned AddW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned RemW    = 9;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam int unsigned Cycle400 = 400;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusClamp   = 2'd2
  } status_e;

  function automatic logic is_leap(input logic [RemW-1:0] rem);
    logic century;
    century = (rem == 9'd0) || (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
    return (rem[1:0] == 2'b00) && (!century || (rem == 9'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [RemW-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

// ===== hw/rtl/gdad_alu.sv =====
`timescale 1ns / 1ps

module gdad_alu #(
  parameter int unsigned Width = 17
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             ge_o,
  output logic             gt_o
);

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = !borrow;
  assign gt_o = !borrow && (diff_o != '0);

endmodule

// ===== hw/rtl/gregorian_date_add_days.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Bits  Contents
// s_axis   in   40    tdata: start_day, start_month, start_year, days_to_add
// m_axis   out  24    tdata: new_day, new_month, new_year; tuser: status
//
// After acceptance, a request reduces start_year modulo 400 by repeated subtraction,
// checks the date, then steps by whole years and by months, with one extra step for
// each January reached, before the result register is loaded; all steps share one
// subtract and compare unit. The input is ready only while the sequencer is idle.
// Reset clears the sequencer and the output valid flag.
// A stalled result stays in the output register and holds back the next result.

module gregorian_date_add_days
  import gdad_pkg::*;
#(
  parameter int unsigned ADD_WIDTH = AddWidthDef,
  parameter int unsigned MAX_YEAR  = MaxYearDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // new_day[4:0], new_month[8:5], new_year[22:9], zero.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status[1:0].
  output logic [StatusW-1:0]  m_axis_tuser_o
);

  localparam int unsigned AwIn  = (ADD_WIDTH < AddW) ? ADD_WIDTH : AddW;
  localparam int unsigned Tw    = AwIn + 1;
  localparam int unsigned YwMin = $clog2(MAX_YEAR + 2);
  localparam int unsigned Yw    = (YwMin > YearW) ? YwMin : YearW;
  localparam int unsigned Uw    = (Tw > Yw) ? Tw : Yw;
  localparam logic [Yw-1:0] MaxYearY = Yw'(MAX_YEAR);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMod   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StRun   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [DayW-1:0]   d_q, d_d;
  logic [MonthW-1:0] m_q, m_d;
  logic [Yw-1:0]     y_q, y_d;
  logic [Yw-1:0]     rem_q, rem_d;
  logic [Tw-1:0]     total_q, total_d;
  logic              yskip_q, yskip_d;
  status_e           status_q, status_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [StatusW-1:0]  out_user_q, out_user_d;

  logic [Uw-1:0]     alu_a, alu_b, alu_diff;
  logic              alu_ge, alu_gt;
  logic              leap, use_year, in_acc, out_load, date_ok;
  logic [DayW-1:0]   mlen;
  logic [RemW-1:0]   ylen;
  logic [AwIn-1:0]   add_in;

  assign leap     = is_leap(rem_q[RemW-1:0]);
  assign mlen     = month_len(m_q, leap);
  assign ylen     = year_len(leap);
  assign use_year = (m_q == MonthJan) && !yskip_q;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == StDone) && (!out_valid_q || m_axis_tready_i);
  assign add_in   = s_axis_tdata_i[23 +: AwIn];
  assign date_ok  = (m_q >= MonthJan) && (m_q <= MonthDec) && (y_q <= MaxYearY) &&
                    (d_q != '0) && (d_q <= mlen);

  always_comb begin
    if (state_q == StMod) begin
      alu_a = Uw'(rem_q);
      alu_b = Uw'(Cycle400);
    end else begin
      alu_a = Uw'(total_q);
      alu_b = use_year ? Uw'(ylen) : Uw'(mlen);
    end
  end

  gdad_alu #(
    .Width (Uw)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge),
    .gt_o   (alu_gt)
  );

  always_comb begin
    logic year_step;
    year_step = 1'b0;
    state_d  = state_q;
    d_d      = d_q;
    m_d      = m_q;
    y_d      = y_q;
    rem_d    = rem_q;
    total_d  = total_q;
    yskip_d  = yskip_q;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          d_d     = s_axis_tdata_i[4:0];
          m_d     = s_axis_tdata_i[8:5];
          y_d     = Yw'(s_axis_tdata_i[22:9]);
          rem_d   = Yw'(s_axis_tdata_i[22:9]);
          total_d = Tw'(s_axis_tdata_i[4:0]) + Tw'(add_in);
          state_d = StMod;
        end
      end
      StMod: begin
        if (alu_ge) begin
          rem_d = alu_diff[Yw-1:0];
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        yskip_d = 1'b0;
        if (date_ok) begin
          state_d = StRun;
        end else begin
          total_d  = '0;
          m_d      = '0;
          y_d      = '0;
          status_d = StatusInvalid;
          state_d  = StDone;
        end
      end
      StRun: begin
        if (use_year) begin
          if (alu_gt) begin
            total_d   = alu_diff[Tw-1:0];
            year_step = 1'b1;
          end else begin
            yskip_d = 1'b1;
          end
        end else if (!alu_gt) begin
          status_d = StatusOk;
          state_d  = StDone;
        end else begin
          total_d = alu_diff[Tw-1:0];
          yskip_d = 1'b0;
          if (m_q == MonthDec) begin
            m_d       = MonthJan;
            year_step = 1'b1;
          end else begin
            m_d = m_q + 4'd1;
          end
        end
        if (year_step) begin
          if (y_q == MaxYearY) begin
            total_d  = Tw'(31);
            m_d      = MonthDec;
            y_d      = MaxYearY;
            status_d = StatusClamp;
            state_d  = StDone;
          end else begin
            y_d   = y_q + Yw'(1);
            rem_d = (rem_q == Yw'(Cycle400 - 1)) ? '0 : rem_q + Yw'(1);
          end
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, y_q[YearW-1:0], m_q, total_q[DayW-1:0]};
      out_user_d  = status_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    m_q        <= m_d;
    y_q        <= y_d;
    rem_q      <= rem_d;
    total_q    <= total_d;
    yskip_q    <= yskip_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTH
  a_accept_starts_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StMod)
    else $error("Accepted request did not start the year reduction.");

  a_run_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> y_q <= MaxYearY && rem_q < Yw'(Cycle400))
    else $error("Year or year phase out of range while stepping.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == StatusInvalid |-> m_axis_tdata_o == '0)
    else $error("Invalid date result carries nonzero fields.");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == StatusOk |->
      m_axis_tdata_o[4:0] != '0 && m_axis_tdata_o[8:5] >= MonthJan &&
      m_axis_tdata_o[8:5] <= MonthDec)
    else $error("Good result has an impossible day or month.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result was lost or changed.");
`endif

endmodule
